[rtl/rsod_pkg.sv]
`default_nettype none

package rsod_pkg;

	localparam int MAX_SAMPLES_DEF = 64;
	localparam int ADC_BITS_DEF    = 10;

	localparam int CNT_REG_W  = 7;
	localparam int LIMIT_W    = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int DIST_W     = 26;
	localparam int FRAC_BITS  = 8;
	localparam int ACC_W      = 64;
	localparam int HALF_W     = 32;
	localparam int HI_SHIFT   = 24;

	localparam logic [CNT_REG_W-1:0] SAMPLE_COUNT_RST = 7'd8;
	localparam logic [LIMIT_W-1:0]   NEAR_LIMIT_RST   = 16'd150;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IR_COUNT    = 2'd0,
		REG_SONAR_COUNT = 2'd1,
		REG_IR_LIMIT    = 2'd2,
		REG_SONAR_LIMIT = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		CH_IR    = 1'b0,
		CH_SONAR = 1'b1
	} channel_t;

	localparam logic [1:0] HORNER_FIRST = 2'd1;
	localparam logic [1:0] HORNER_LAST  = 2'd3;

	// Curve coefficients in Q.32, highest power first
	localparam logic [ACC_W-1:0] IR_COEF [4] = '{
		-64'sd171111,
		64'sd196236957,
		-64'sd75099031105,
		64'sd11042587327217
	};
	localparam logic [ACC_W-1:0] SONAR_COEF [4] = '{
		64'sd76879915,
		-64'sd4961975717,
		64'sd168938243621,
		-64'sd434994287739
	};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_ABS,
		ST_MULH,
		ST_MULL,
		ST_SUM,
		ST_ADD,
		ST_MAG,
		ST_FINAL
	} state_t;

	typedef struct packed {
		logic       accept;
		logic       div_start;
		logic       horner_init;
		logic       do_abs;
		logic       do_mulh;
		logic       do_mull;
		logic       do_sum;
		logic       do_add;
		logic       do_final;
		logic [1:0] stage;
	} dp_cmd_t;

	typedef struct packed {
		logic hit;
		logic div_done;
		logic out_free;
	} dp_stat_t;

	function automatic logic [ACC_W-1:0] horner_coef(input logic ch, input logic [1:0] k);
		return (ch == CH_SONAR) ? SONAR_COEF[k] : IR_COEF[k];
	endfunction

endpackage

`default_nettype wire

[rtl/rsod_if.sv]
`default_nettype none

interface rsod_sample_if import rsod_pkg::*; #(
	parameter int ADC_BITS = ADC_BITS_DEF
);
	logic                valid;
	logic                ready;
	logic                sensor_channel;
	logic [ADC_BITS-1:0] adc_sample;

	modport source (output valid, output sensor_channel, output adc_sample, input ready);
	modport sink (input valid, input sensor_channel, input adc_sample, output ready);
endinterface

interface rsod_result_if import rsod_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic                     result_channel;
	logic signed [DIST_W-1:0] distance_mm;
	logic                     channel_near;
	logic                     obstacle_any;

	modport source (
		output valid, output result_channel, output distance_mm,
		output channel_near, output obstacle_any, input ready
	);
	modport sink (
		input valid, input result_channel, input distance_mm,
		input channel_near, input obstacle_any, output ready
	);
endinterface

`default_nettype wire

[rtl/rsod_div.sv]
`default_nettype none

module rsod_div #(
	parameter int DVD_W = 25,
	parameter int DIV_W = 7
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DIV_W-1:0] divisor,
	output logic      [DVD_W-1:0] quotient,
	output logic                  done
);

	localparam int ITER_W = $clog2(DVD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [ITER_W-1:0] iter_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dsr_q;
	logic [DIV_W:0]    rem_sh;
	logic [DIV_W:0]    diff;
	logic              ge;

	always_comb begin
		rem_sh = {rem_q, quo_q[DVD_W-1]};
		ge     = rem_sh >= {1'b0, dsr_q};
		diff   = rem_sh - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= busy_q && (iter_q == ITER_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= ITER_W'(DVD_W);
			end else if (busy_q) begin
				iter_q <= iter_q - ITER_W'(1);
				if (iter_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// one quotient bit per cycle, dividend shifts out as quotient shifts in
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

`default_nettype wire

[rtl/rsod_dp.sv]
`default_nettype none

module rsod_dp import rsod_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
	parameter int ADC_BITS    = ADC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  sensor_channel,
	input  wire logic [ADC_BITS-1:0]   adc_sample,
	input  wire dp_cmd_t               cmd,
	output dp_stat_t                   stat,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       result_channel,
	output logic signed [DIST_W-1:0]   distance_mm,
	output logic                       channel_near,
	output logic                       obstacle_any
);

	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W  = ADC_BITS + CNT_W;
	localparam int AVG_W  = ADC_BITS + FRAC_BITS;
	localparam int DVD_W  = SUM_W + FRAC_BITS;
	localparam int CMP_W  = (CNT_W > CNT_REG_W) ? CNT_W : CNT_REG_W;
	localparam int PROD_W = HALF_W + AVG_W;

	// configuration
	logic [CNT_REG_W-1:0] ir_count_reg_q, sonar_count_reg_q;
	logic [LIMIT_W-1:0]   ir_limit_q, sonar_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ir_count_reg_q    <= SAMPLE_COUNT_RST;
			sonar_count_reg_q <= SAMPLE_COUNT_RST;
			ir_limit_q        <= NEAR_LIMIT_RST;
			sonar_limit_q     <= NEAR_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_IR_COUNT:    ir_count_reg_q    <= cfg_wdata[CNT_REG_W-1:0];
				REG_SONAR_COUNT: sonar_count_reg_q <= cfg_wdata[CNT_REG_W-1:0];
				REG_IR_LIMIT:    ir_limit_q        <= cfg_wdata[LIMIT_W-1:0];
				REG_SONAR_LIMIT: sonar_limit_q     <= cfg_wdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// accumulation
	logic [SUM_W-1:0]     ir_sum_q, sonar_sum_q, sum_new;
	logic [CNT_W-1:0]     ir_cnt_q, sonar_cnt_q, cnt_new;
	logic [CNT_REG_W-1:0] cnt_reg;
	logic [CMP_W-1:0]     target;
	logic                 hit;

	always_comb begin
		sum_new = ((sensor_channel == CH_SONAR) ? sonar_sum_q : ir_sum_q)
			+ SUM_W'(adc_sample);
		cnt_new = ((sensor_channel == CH_SONAR) ? sonar_cnt_q : ir_cnt_q) + CNT_W'(1);
		cnt_reg = (sensor_channel == CH_SONAR) ? sonar_count_reg_q : ir_count_reg_q;
		if (cnt_reg == '0) begin
			target = CMP_W'(1);
		end else if (CMP_W'(cnt_reg) > CMP_W'(MAX_SAMPLES)) begin
			target = CMP_W'(MAX_SAMPLES);
		end else begin
			target = CMP_W'(cnt_reg);
		end
		hit = CMP_W'(cnt_new) >= target;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ir_sum_q    <= '0;
			sonar_sum_q <= '0;
			ir_cnt_q    <= '0;
			sonar_cnt_q <= '0;
		end else if (cmd.accept) begin
			// clear the channel as its average goes off to the divider
			if (sensor_channel == CH_SONAR) begin
				sonar_sum_q <= hit ? '0 : sum_new;
				sonar_cnt_q <= hit ? '0 : cnt_new;
			end else begin
				ir_sum_q <= hit ? '0 : sum_new;
				ir_cnt_q <= hit ? '0 : cnt_new;
			end
		end
	end

	// average
	logic [DVD_W-1:0] quotient;
	logic             div_done;
	logic             ch_q;

	rsod_div #(
		.DVD_W (DVD_W),
		.DIV_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({sum_new, FRAC_BITS'(0)}),
		.divisor  (cnt_new),
		.quotient (quotient),
		.done     (div_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			ch_q <= sensor_channel;
		end
	end

	// Horner evaluation on one shared multiplier
	logic [AVG_W-1:0]  avg_q;
	logic [ACC_W-1:0]  acc_q, mag_q, part_q, r_q, coef;
	logic [PROD_W-1:0] prod_q;
	logic              neg_q;
	logic [HALF_W-1:0] mul_a;

	always_comb begin
		mul_a = cmd.do_mulh ? mag_q[ACC_W-1:HALF_W] : mag_q[HALF_W-1:0];
		coef  = horner_coef(ch_q, cmd.stage);
	end

	always_ff @(posedge clk) begin
		if (cmd.horner_init) begin
			avg_q <= quotient[AVG_W-1:0];
			acc_q <= horner_coef(ch_q, 2'd0);
		end
		if (cmd.do_abs) begin
			neg_q <= acc_q[ACC_W-1];
			mag_q <= acc_q[ACC_W-1] ? (ACC_W'(0) - acc_q) : acc_q;
		end
		if (cmd.do_mulh || cmd.do_mull) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(avg_q);
		end
		if (cmd.do_mull) begin
			part_q <= ACC_W'(prod_q) << HI_SHIFT;
		end
		if (cmd.do_sum) begin
			r_q <= part_q + ACC_W'(prod_q >> FRAC_BITS);
		end
		if (cmd.do_add) begin
			acc_q <= neg_q ? (coef - r_q) : (coef + r_q);
		end
	end

	// distance, flags, output register
	logic [HALF_W-1:0]  whole;
	logic [DIST_W-1:0]  dist_mag, dist_val;
	logic [LIMIT_W-1:0] limit;
	logic               near;
	logic               out_free;
	logic               ir_near_q, sonar_near_q;
	logic               out_valid_q;
	logic               res_ch_q, res_near_q, res_any_q;
	logic [DIST_W-1:0]  res_dist_q;

	always_comb begin
		whole    = mag_q[ACC_W-1:HALF_W];
		dist_mag = mag_q[HALF_W +: DIST_W];
		dist_val = neg_q ? (DIST_W'(0) - dist_mag) : dist_mag;
		limit    = (ch_q == CH_SONAR) ? sonar_limit_q : ir_limit_q;
		near     = neg_q || (whole <= HALF_W'(limit));
		out_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ir_near_q    <= 1'b0;
			sonar_near_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.do_final) begin
				out_valid_q <= 1'b1;
				if (ch_q == CH_SONAR) begin
					sonar_near_q <= near;
				end else begin
					ir_near_q <= near;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_final) begin
			res_ch_q   <= ch_q;
			res_dist_q <= dist_val;
			res_near_q <= near;
			res_any_q  <= near || ((ch_q == CH_SONAR) ? ir_near_q : sonar_near_q);
		end
	end

	assign stat           = '{hit: hit, div_done: div_done, out_free: out_free};
	assign out_valid      = out_valid_q;
	assign result_channel = res_ch_q;
	assign distance_mm    = $signed(res_dist_q);
	assign channel_near   = res_near_q;
	assign obstacle_any   = res_any_q;

endmodule

`default_nettype wire

[rtl/rsod_ctrl.sv]
`default_nettype none

module rsod_ctrl import rsod_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	state_t     state_q, state_d;
	logic [1:0] stage_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid && stat.hit) state_d = ST_DIV;
			ST_DIV:   if (stat.div_done) state_d = ST_ABS;
			ST_ABS:   state_d = ST_MULH;
			ST_MULH:  state_d = ST_MULL;
			ST_MULL:  state_d = ST_SUM;
			ST_SUM:   state_d = ST_ADD;
			ST_ADD:   state_d = (stage_q == HORNER_LAST) ? ST_MAG : ST_ABS;
			ST_MAG:   state_d = ST_FINAL;
			ST_FINAL: if (stat.out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.stage = stage_q;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.accept    = in_valid;
				cmd.div_start = in_valid && stat.hit;
			end
			ST_DIV:   cmd.horner_init = stat.div_done;
			ST_ABS:   cmd.do_abs      = 1'b1;
			ST_MULH:  cmd.do_mulh     = 1'b1;
			ST_MULL:  cmd.do_mull     = 1'b1;
			ST_SUM:   cmd.do_sum      = 1'b1;
			ST_ADD:   cmd.do_add      = 1'b1;
			ST_MAG:   cmd.do_abs      = 1'b1;
			ST_FINAL: cmd.do_final    = stat.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stage_q <= HORNER_FIRST;
		end else begin
			state_q <= state_d;
			if (cmd.horner_init) begin
				stage_q <= HORNER_FIRST;
			end else if (cmd.do_add) begin
				stage_q <= stage_q + 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/range_sensor_obstacle_detector_core.sv]
// Channel     Dir  Beat contents
// sample_in   in   sensor_channel, adc_sample
// result_out  out  result_channel, distance_mm, channel_near, obstacle_any
// cfg_*       in   register index and write data, one write per enabled cycle
//
// A sample that does not complete an average is taken in the idle state and leaves
// the input open. A completing sample closes the input until its result is loaded:
// the bit-serial divider forms the 10.8 average in SUM_W + 8 steps, the average is
// loaded, three Horner stages of abs, high multiply, low multiply, sum and add run
// on one shared 32-bit multiplier, then sign, compare and output load. The result is
// valid as the input reopens.
// Reset clears the sums, counts and near flags and loads the register defaults.
// While a result waits on result_out, samples keep being taken; only a new result
// stalls until the output register is free.
`default_nettype none

module range_sensor_obstacle_detector_core import rsod_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
	parameter int ADC_BITS    = ADC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	rsod_sample_if.sink                sample_in,
	rsod_result_if.source              result_out
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     in_ready;

	rsod_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample_in.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rsod_dp #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.ADC_BITS    (ADC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.sensor_channel (sample_in.sensor_channel),
		.adc_sample     (sample_in.adc_sample),
		.cmd            (cmd),
		.stat           (stat),
		.out_valid      (result_out.valid),
		.out_ready      (result_out.ready),
		.result_channel (result_out.result_channel),
		.distance_mm    (result_out.distance_mm),
		.channel_near   (result_out.channel_near),
		.obstacle_any   (result_out.obstacle_any)
	);

	assign sample_in.ready = in_ready;

endmodule

`default_nettype wire
